### hdl/bsrp_pkg.sv
`timescale 1ns / 1ps

package bsrp_pkg;

    localparam int BUF_DEPTH     = 256;
    localparam int AW            = $clog2(BUF_DEPTH);
    localparam int PAYLOAD_BYTES = 63;
    localparam int CW            = $clog2(PAYLOAD_BYTES + 1);
    localparam int BYTE_W        = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QAW           = $clog2(QUEUE_DEPTH);
    localparam int QCW           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd5;
    localparam logic [BYTE_W-1:0] WAIT_MAX      = 8'hFF;

    // item kinds carried on s_tuser
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // command from the classifier to the report engine
    typedef struct packed {
        logic              is_ovf;  // overflow result, val is the dropped byte
        logic [BYTE_W-1:0] val;     // dropped byte or report length
    } cmd_t;

    // ring buffer write port
    typedef struct packed {
        logic              en;
        logic [AW-1:0]     addr;
        logic [BYTE_W-1:0] data;
    } wr_port_t;

endpackage

### hdl/bsrp_front.sv
`timescale 1ns / 1ps

module bsrp_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       s_tuser,
    input  logic [bsrp_pkg::BYTE_W-1:0] s_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [bsrp_pkg::BYTE_W-1:0] cfg_data,
    input  logic [bsrp_pkg::AW-1:0]    phys_rd_ptr,
    output logic                       cmd_valid,
    output bsrp_pkg::cmd_t             cmd,
    input  logic                       cmd_ready,
    output bsrp_pkg::wr_port_t         wr
);
    import bsrp_pkg::*;

    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [BYTE_W-1:0] wait_reg, wait_next;
    logic [BYTE_W-1:0] timeout_reg;
    logic [AW-1:0]     held;
    logic              log_full, phys_full, accept, is_push;
    logic              full_rep, timed, send_rep;
    logic [CW-1:0]     take;

    assign cfg_ready = 1'b1;

    assign held      = wr_ptr_reg - rd_ptr_reg;
    assign log_full  = held == AW'(BUF_DEPTH - 1);
    // slot after the write pointer still waits to be read out
    assign phys_full = AW'(wr_ptr_reg + 1'b1) == phys_rd_ptr;
    assign s_tready  = cmd_ready && !(phys_full && rd_ptr_reg != phys_rd_ptr);
    assign accept    = s_tvalid && s_tready;
    assign is_push   = s_tuser == OP_PUSH;

    assign full_rep  = held >= AW'(PAYLOAD_BYTES);
    assign timed     = wait_reg >= timeout_reg;
    assign take      = full_rep ? CW'(PAYLOAD_BYTES) : held[CW-1:0];
    assign send_rep  = !is_push && held != '0 && (full_rep || timed);

    assign cmd_valid  = accept && ((is_push && log_full) || send_rep);
    assign cmd.is_ovf = is_push;
    assign cmd.val    = is_push ? s_tdata : BYTE_W'(take);

    assign wr.en   = accept && is_push && !log_full;
    assign wr.addr = wr_ptr_reg;
    assign wr.data = s_tdata;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        wait_next   = wait_reg;
        if (wr.en) begin
            wr_ptr_next = AW'(wr_ptr_reg + 1'b1);
        end
        if (accept && send_rep) begin
            rd_ptr_next = AW'(rd_ptr_reg + AW'(take));
            wait_next   = '0;
        end else if (accept && !is_push && held != '0 && wait_reg != WAIT_MAX) begin
            wait_next = wait_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            wait_reg    <= '0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            wait_reg   <= wait_next;
            if (cfg_valid && cfg_ready) begin
                timeout_reg <= cfg_data;
            end
        end
    end

endmodule

### hdl/bsrp_queue.sv
`timescale 1ns / 1ps

module bsrp_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  bsrp_pkg::cmd_t in_cmd,
    output logic           in_ready,
    output logic           out_valid,
    output bsrp_pkg::cmd_t out_cmd,
    input  logic           out_ready
);
    import bsrp_pkg::*;

    cmd_t           q_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_idx_reg, rd_idx_reg;
    logic [QCW-1:0] count_reg;
    logic           push, pop;

    assign in_ready  = count_reg != QCW'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = q_reg[rd_idx_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_idx_reg <= (wr_idx_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(wr_idx_reg + 1'b1);
            end
            if (pop) begin
                rd_idx_reg <= (rd_idx_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : QAW'(rd_idx_reg + 1'b1);
            end
            if (push && !pop) begin
                count_reg <= QCW'(count_reg + 1'b1);
            end else if (pop && !push) begin
                count_reg <= QCW'(count_reg - 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_idx_reg] <= in_cmd;
        end
    end

endmodule

### hdl/bsrp_back.sv
`timescale 1ns / 1ps

module bsrp_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    input  bsrp_pkg::cmd_t              cmd,
    output logic                        cmd_ready,
    input  bsrp_pkg::wr_port_t          wr,
    output logic [bsrp_pkg::AW-1:0]     phys_rd_ptr,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bsrp_pkg::BYTE_W-1:0] m_tdata,
    output logic                        m_tlast,
    output logic                        m_tuser
);
    import bsrp_pkg::*;

    logic [BYTE_W-1:0] ring_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    logic              busy_reg, busy_next;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     take_reg, take_next;
    logic [AW-1:0]     prd_reg, prd_next;

    // element stage ahead of the output register
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_mem_reg, s1_mem_next;
    logic [BYTE_W-1:0] s1_val_reg, s1_val_next;
    logic              s1_last_reg, s1_last_next;
    logic              s1_ovf_reg, s1_ovf_next;

    logic              m_valid_reg;
    logic [BYTE_W-1:0] m_data_reg;
    logic              m_last_reg, m_ovf_reg;

    logic              out_free, s1_move, s1_free, pop, gen, is_data, rd_en;

    assign out_free  = !m_valid_reg || m_tready;
    assign s1_move   = s1_valid_reg && out_free;
    assign s1_free   = !s1_valid_reg || s1_move;
    assign cmd_ready = !busy_reg && s1_free;
    assign pop       = cmd_valid && cmd_ready;
    assign gen       = busy_reg && s1_free;
    assign is_data   = k_reg <= take_reg;
    assign rd_en     = gen && is_data;

    assign phys_rd_ptr = prd_reg;
    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign m_tlast     = m_last_reg;
    assign m_tuser     = m_ovf_reg;

    always_comb begin
        busy_next     = busy_reg;
        k_next        = k_reg;
        take_next     = take_reg;
        prd_next      = prd_reg;
        s1_valid_next = s1_valid_reg;
        s1_mem_next   = s1_mem_reg;
        s1_val_next   = s1_val_reg;
        s1_last_next  = s1_last_reg;
        s1_ovf_next   = s1_ovf_reg;
        if (pop) begin
            // overflow result or the length byte of a report
            s1_valid_next = 1'b1;
            s1_mem_next   = 1'b0;
            s1_val_next   = cmd.val;
            s1_last_next  = cmd.is_ovf;
            s1_ovf_next   = cmd.is_ovf;
            busy_next     = !cmd.is_ovf;
            k_next        = CW'(1);
            take_next     = cmd.val[CW-1:0];
        end else if (gen) begin
            s1_valid_next = 1'b1;
            s1_mem_next   = is_data;
            s1_val_next   = '0;
            s1_last_next  = k_reg == CW'(PAYLOAD_BYTES);
            s1_ovf_next   = 1'b0;
            k_next        = CW'(k_reg + 1'b1);
            busy_next     = k_reg != CW'(PAYLOAD_BYTES);
            if (rd_en) begin
                prd_next = AW'(prd_reg + 1'b1);
            end
        end else if (s1_move) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            k_reg        <= '0;
            prd_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            k_reg        <= k_next;
            prd_reg      <= prd_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        take_reg    <= take_next;
        s1_mem_reg  <= s1_mem_next;
        s1_val_reg  <= s1_val_next;
        s1_last_reg <= s1_last_next;
        s1_ovf_reg  <= s1_ovf_next;
        if (s1_move) begin
            m_data_reg <= s1_mem_reg ? rd_data_reg : s1_val_reg;
            m_last_reg <= s1_last_reg;
            m_ovf_reg  <= s1_ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            ring_mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring_mem[prd_reg];
        end
    end

    a_ovf_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_ovf_reg |-> m_last_reg)
        else $error("overflow result without last");

    a_read_in_report: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> busy_reg && k_reg != '0)
        else $error("ring read outside a report body");

    a_report_len: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !cmd.is_ovf |-> cmd.val <= BYTE_W'(PAYLOAD_BYTES) && cmd.val != '0)
        else $error("report length out of range");

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !$past(pop) |=> $past(k_reg) != k_reg || !$past(gen))
        else $error("report counter stuck while generating");

endmodule

### hdl/byte_stream_report_packer_core.sv
`timescale 1ns / 1ps

// channel   | direction | tdata / data       | tuser      | tlast
// s_        | in        | [7:0] data_byte    | [0] op     | -
// m_        | out       | [7:0] out_byte     | [0] overflow | [0] last
// cfg_      | in        | [7:0] flush_timeout| -          | -
//
// a report streams its 64 bytes one per cycle while m_tready is high, behind a
// classifier, a two-entry command queue and a registered ring read
// the input stalls only while the command queue is full or the next write slot
// still holds a byte queued for a report that has not been read out yet
// reset (aresetn low, synchronous) empties the buffer, clears the wait counter
// and sets flush_timeout to 5; ring contents are not cleared
// the output register lets the next item be accepted while a byte waits on m_tready

module byte_stream_report_packer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input item transfer
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bsrp_pkg::BYTE_W-1:0] s_tdata,   // [7:0] data_byte
    input  logic                        s_tuser,   // [0] op: 0 push, 1 tick
    // result transfer
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bsrp_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic                        m_tlast,   // last byte of a report or overflow
    output logic                        m_tuser,   // [0] overflow
    // flush_timeout write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [bsrp_pkg::BYTE_W-1:0] cfg_data
);
    import bsrp_pkg::*;

    // classifier to queue
    logic     f_cmd_valid, f_cmd_ready;
    cmd_t     f_cmd;
    // queue to report engine
    logic     q_cmd_valid, q_cmd_ready;
    cmd_t     q_cmd;
    // ring write port and read pointer shared between the halves
    wr_port_t wr;
    logic [AW-1:0] phys_rd_ptr;

    // front: buffer bookkeeping, tick decisions, overflow detection
    bsrp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .phys_rd_ptr (phys_rd_ptr),
        .cmd_valid   (f_cmd_valid),
        .cmd         (f_cmd),
        .cmd_ready   (f_cmd_ready),
        .wr          (wr)
    );

    // short command queue decoupling the two halves
    bsrp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_cmd_valid),
        .in_cmd    (f_cmd),
        .in_ready  (f_cmd_ready),
        .out_valid (q_cmd_valid),
        .out_cmd   (q_cmd),
        .out_ready (q_cmd_ready)
    );

    // back: ring memory and report streaming
    bsrp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (q_cmd_valid),
        .cmd         (q_cmd),
        .cmd_ready   (q_cmd_ready),
        .wr          (wr),
        .phys_rd_ptr (phys_rd_ptr),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule
